>>> rtl/core/ptd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types and constants for the priority task dispatcher.
// ----------------------------------------------------------------------------
package ptd_pkg;

   localparam int CAPACITY_DEF = 64;

   localparam int ID_W    = 16;
   localparam int PRIO_W  = 8;
   localparam int BURST_W = 16;

   // request kinds carried on tuser
   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_SCHED = 1'b1;

   // one stored task
   typedef struct packed {
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  prio;
      logic [ID_W-1:0]    id;
   } slot_type;

   // one dispatched task
   typedef struct packed {
      logic               last;
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  prio;
      logic [ID_W-1:0]    id;
   } result_type;

   typedef enum logic [1:0] {
      SCH_IDLE,
      SCH_SCAN,
      SCH_LAST,
      SCH_EMIT
   } sched_state_type;

endpackage

>>> rtl/core/ptd_slot_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptd_slot_ram
// Task slot storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ptd_slot_ram #(
   parameter int DEPTH = ptd_pkg::CAPACITY_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  ptd_pkg::slot_type        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output ptd_pkg::slot_type        rd_data
);

   ptd_pkg::slot_type mem [DEPTH];
   ptd_pkg::slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/ptd_sched.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptd_sched
// Add / drain sequencer: appends tasks to the slot RAM and, on a drain,
// scans the RAM once per result to pick the highest-priority pending task.
// ----------------------------------------------------------------------------
module ptd_sched #(
   parameter int CAPACITY = ptd_pkg::CAPACITY_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request side
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [ptd_pkg::PRIO_W-1:0]    req_prio,
   input  logic [ptd_pkg::BURST_W-1:0]   req_burst,
   // slot RAM
   output logic                          ram_we,
   output logic [$clog2(CAPACITY)-1:0]   ram_waddr,
   output ptd_pkg::slot_type             ram_wdata,
   output logic                          ram_re,
   output logic [$clog2(CAPACITY)-1:0]   ram_raddr,
   input  ptd_pkg::slot_type             ram_rdata,
   // result push
   output logic                          push_valid,
   input  logic                          push_ready,
   output ptd_pkg::result_type           push_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   ptd_pkg::sched_state_type state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             remain_ff, remain_in;
   logic [ptd_pkg::ID_W-1:0]  next_id_ff, next_id_in;
   logic [CAPACITY-1:0]       done_ff, done_in;
   logic [AW-1:0]             scan_idx_ff, scan_idx_in;
   logic                      rd_vld_ff, rd_vld_in;
   logic [AW-1:0]             rd_idx_ff, rd_idx_in;
   logic                      best_vld_ff, best_vld_in;
   logic [AW-1:0]             best_idx_ff, best_idx_in;
   ptd_pkg::slot_type         best_ff, best_in;
   logic [CW-1:0]             count_m1;
   logic [AW-1:0]             last_idx;

   assign count_m1 = count_ff - CW'(1);
   assign last_idx = count_m1[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ptd_pkg::SCH_IDLE;
         count_ff    <= '0;
         remain_ff   <= '0;
         next_id_ff  <= '0;
         done_ff     <= '0;
         rd_vld_ff   <= 1'b0;
         best_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         remain_ff   <= remain_in;
         next_id_ff  <= next_id_in;
         done_ff     <= done_in;
         rd_vld_ff   <= rd_vld_in;
         best_vld_ff <= best_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      rd_idx_ff   <= rd_idx_in;
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      remain_in   = remain_ff;
      next_id_in  = next_id_ff;
      done_in     = done_ff;
      scan_idx_in = scan_idx_ff;
      rd_vld_in   = 1'b0;
      rd_idx_in   = scan_idx_ff;
      best_vld_in = best_vld_ff;
      best_idx_in = best_idx_ff;
      best_in     = best_ff;

      req_ready       = (state_ff == ptd_pkg::SCH_IDLE);
      ram_we          = 1'b0;
      ram_waddr       = count_ff[AW-1:0];
      ram_wdata.id    = next_id_ff;
      ram_wdata.prio  = req_prio;
      ram_wdata.burst = req_burst;
      ram_re          = 1'b0;
      ram_raddr       = scan_idx_ff;
      push_valid      = 1'b0;
      push_data.id    = best_ff.id;
      push_data.prio  = best_ff.prio;
      push_data.burst = best_ff.burst;
      push_data.last  = (remain_ff == CW'(1));

      // strict greater-than keeps the earliest slot on a priority tie
      if (rd_vld_ff && !done_ff[rd_idx_ff] &&
          (!best_vld_ff || (ram_rdata.prio > best_ff.prio))) begin
         best_vld_in = 1'b1;
         best_idx_in = rd_idx_ff;
         best_in     = ram_rdata;
      end

      case (state_ff)
         ptd_pkg::SCH_IDLE: begin
            if (req_valid) begin
               if (req_func == ptd_pkg::FUNC_ADD) begin
                  if (count_ff < CW'(CAPACITY)) begin
                     ram_we     = 1'b1;
                     count_in   = count_ff + CW'(1);
                     next_id_in = next_id_ff + ptd_pkg::ID_W'(1);
                  end
               end else if (count_ff != '0) begin
                  remain_in   = count_ff;
                  scan_idx_in = '0;
                  best_vld_in = 1'b0;
                  state_in    = ptd_pkg::SCH_SCAN;
               end
            end
         end
         ptd_pkg::SCH_SCAN: begin
            ram_re    = 1'b1;
            rd_vld_in = 1'b1;
            if (scan_idx_ff == last_idx) begin
               state_in = ptd_pkg::SCH_LAST;
            end else begin
               scan_idx_in = scan_idx_ff + AW'(1);
            end
         end
         ptd_pkg::SCH_LAST: begin
            // final read data is folded in this cycle
            state_in = ptd_pkg::SCH_EMIT;
         end
         ptd_pkg::SCH_EMIT: begin
            push_valid = 1'b1;
            if (push_ready) begin
               done_in[best_idx_ff] = 1'b1;
               remain_in            = remain_ff - CW'(1);
               if (remain_ff == CW'(1)) begin
                  done_in  = '0;
                  count_in = '0;
                  state_in = ptd_pkg::SCH_IDLE;
               end else begin
                  scan_idx_in = '0;
                  best_vld_in = 1'b0;
                  state_in    = ptd_pkg::SCH_SCAN;
               end
            end
         end
         default: begin
            state_in = ptd_pkg::SCH_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/core/ptd_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptd_out_reg
// Single-entry output register between the sequencer and the result stream.
// ----------------------------------------------------------------------------
module ptd_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  ptd_pkg::result_type push_data,
   output logic                out_valid,
   input  logic                out_ready,
   output ptd_pkg::result_type out_data
);

   logic                full_ff, full_in;
   ptd_pkg::result_type data_ff;

   assign push_ready = !full_ff || out_ready;
   assign full_in    = push_valid || (full_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid && push_ready) begin
         data_ff <= push_data;
      end
   end

   assign out_valid = full_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/core/priority_task_dispatcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_task_dispatcher
// Task table with non-preemptive priority dispatch: adds append tasks,
// a schedule beat drains them highest priority first, earliest on ties.
// ----------------------------------------------------------------------------
//  Channel | Dir | Ports                          | Beat
//  req     | in  | req_tvalid/tready/tdata/tuser  | add (tuser=0) or schedule (tuser=1)
//  rsp     | out | rsp_tvalid/tready/tdata/tlast  | one dispatched task, tlast on final
//
//  Add beat: a full table drops the add.
//  Schedule of N tasks: each result rescans all N slots through the single
//  RAM read port, folds the last read data in, then emits the pick.
//  Reset clears the table at once (pending bits and fill count are flops).
//  req_tready is low for the whole drain; a stalled rsp holds the scan.
// ----------------------------------------------------------------------------
module priority_task_dispatcher #(
   parameter int CAPACITY = ptd_pkg::CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] task_priority, [23:8] task_burst
   input  logic        req_tuser,   // [0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [15:0] task_id, [23:16] run_priority,
                                    // [39:24] run_burst
   output logic        rsp_tlast    // last_task
);

   localparam int AW = $clog2(CAPACITY);

   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   ptd_pkg::slot_type   ram_wdata;
   logic                ram_re;
   logic [AW-1:0]       ram_raddr;
   ptd_pkg::slot_type   ram_rdata;
   logic                push_valid;
   logic                push_ready;
   ptd_pkg::result_type push_data;
   ptd_pkg::result_type out_data;

   ptd_sched #(
      .CAPACITY (CAPACITY)
   ) u_sched (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_func   (req_tuser),
      .req_prio   (req_tdata[7:0]),
      .req_burst  (req_tdata[23:8]),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   ptd_slot_ram #(
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   ptd_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (out_data)
   );

   assign rsp_tdata = {out_data.burst, out_data.prio, out_data.id};
   assign rsp_tlast = out_data.last;

endmodule

>>> rtl/core/ptd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptd_checker
// Port-level checks for the priority task dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
module ptd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   // stalled result beat stays up
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   // stalled result beat keeps its payload
   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp payload changed while stalled");

   // a pending non-final result means the drain is still running
   a_drain_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request taken in the middle of a drain");

   // an accepted add leaves req_tready high on the next cycle
   a_add_single : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == 1'b0) |=> req_tready)
      else $error("add beat did not complete in one cycle");

   // offered request beat carries known fields
   a_req_known : assert property (@(posedge clock) disable iff (reset)
      req_tvalid |-> !$isunknown({req_tuser, req_tdata}))
      else $error("request beat has unknown fields");

endmodule

bind priority_task_dispatcher ptd_checker u_ptd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
